// File: rtl/core/pctesc_pkg.sv
// shared types, constants and character helpers of the percent codec
package pctesc_pkg;

  // mode register layout: bit 1 selects unescape, bit 0 selects the uri set
  localparam int unsigned ModeW        = 2;
  localparam int unsigned MODE_UNESC_BIT = 1;
  localparam int unsigned MODE_URI_BIT   = 0;

  // depth of the token queue between front and back
  localparam int unsigned TOK_DEPTH = 4;

  // default string length limit for the escape modes
  localparam int unsigned MAX_LENGTH_DEF = 32766;

  localparam logic [7:0] CHAR_PCT = 8'h25;

  // beat positions inside an escaped triple
  localparam logic [1:0] BEAT_PCT = 2'd0;
  localparam logic [1:0] BEAT_HI  = 2'd1;
  localparam logic [1:0] BEAT_LO  = 2'd2;

  typedef enum logic {
    KIND_COPY = 1'b0,
    KIND_ESC  = 1'b1
  } kind_e;

  // one unit of output work: a copied byte or a byte sent as three beats
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       tl;
    logic       last;
  } tok_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    hex_value = v[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

  // characters kept as they are in the escape modes; the uri set adds @#=?/:
  function automatic logic passes(input logic [7:0] c, input logic uri);
    logic ok;
    ok = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
         (c >= 8'h30 && c <= 8'h39);
    case (c)
      8'h21, 8'h2d, 8'h5f, 8'h2e, 8'h7e: ok = 1'b1;
      8'h40, 8'h23, 8'h3d, 8'h3f, 8'h2f, 8'h3a: ok = ok | uri;
      default: ok = ok;
    endcase
    passes = ok;
  endfunction

endpackage

// File: rtl/core/pctesc_front.sv
// front end: lookahead window, classification and token generation
module pctesc_front #(
  parameter int unsigned MAX_LENGTH = pctesc_pkg::MAX_LENGTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pctesc_pkg::ModeW-1:0]  cfg_wdata_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  output logic                          tok_push_o,
  output pctesc_pkg::tok_t              tok_o,
  input  logic                          tok_full_i
);

  logic [pctesc_pkg::ModeW-1:0] mode_q;
  logic [7:0]  win_q [3];
  logic [7:0]  win_s [3];
  logic [7:0]  win_d [3];
  logic [1:0]  cnt_q, cnt_s, cnt_d;
  logic        last_q, tl_q, tl_d;
  logic [15:0] len_q, len_d, len_inc;
  logic        unesc, uri, h1, h2, is_pct, brk, enc, take3, fire, ready, accept;

  assign unesc  = mode_q[pctesc_pkg::MODE_UNESC_BIT];
  assign uri    = mode_q[pctesc_pkg::MODE_URI_BIT];
  assign is_pct = (win_q[0] == pctesc_pkg::CHAR_PCT);
  assign h1     = pctesc_pkg::is_hex(win_q[1]);
  assign h2     = pctesc_pkg::is_hex(win_q[2]);

  // a percent whose following digits have not all arrived waits for more input
  assign brk = (cnt_q != 2'd0) && is_pct && !last_q &&
               ((cnt_q == 2'd1) || ((cnt_q == 2'd2) && h1));
  assign enc   = is_pct && (cnt_q == 2'd3) && h1 && h2;
  assign take3 = enc && unesc;
  assign fire  = (cnt_q != 2'd0) && !brk && !tok_full_i;

  // window after this cycle's step
  always_comb begin
    cnt_s    = cnt_q;
    win_s[0] = win_q[0];
    win_s[1] = win_q[1];
    win_s[2] = win_q[2];
    if (fire) begin
      cnt_s    = cnt_q - (take3 ? 2'd3 : 2'd1);
      win_s[0] = win_q[1];
      win_s[1] = win_q[2];
    end
  end

  // token for the head of the window
  always_comb begin
    tok_o.kind = (!enc && !unesc && !pctesc_pkg::passes(win_q[0], uri)) ?
                 pctesc_pkg::KIND_ESC : pctesc_pkg::KIND_COPY;
    tok_o.data = take3 ? {pctesc_pkg::hex_value(win_q[1]), pctesc_pkg::hex_value(win_q[2])}
                       : win_q[0];
    tok_o.tl   = tl_q;
    tok_o.last = last_q && (cnt_s == 2'd0);
  end
  assign tok_push_o = fire;

  // input side: free once the window is drained or waiting on a percent
  assign ready  = (cnt_q == 2'd0) || brk || (fire && (cnt_s == 2'd0));
  assign full_o = !ready;
  assign accept = push_i && ready;

  assign len_inc = (len_q == 16'hffff) ? len_q : len_q + 16'd1;

  always_comb begin
    win_d[0] = win_s[0];
    win_d[1] = win_s[1];
    win_d[2] = win_s[2];
    cnt_d    = cnt_s;
    len_d    = len_q;
    tl_d     = tl_q;
    if (accept) begin
      win_d[cnt_s] = in_byte_i;
      cnt_d        = cnt_s + 2'd1;
      tl_d         = !unesc && ({1'b0, len_inc} > 17'(MAX_LENGTH));
      len_d        = in_last_i ? 16'd0 : len_inc;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      cnt_q  <= 2'd0;
      len_q  <= 16'd0;
      last_q <= 1'b0;
      tl_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
      len_q <= len_d;
      tl_q  <= tl_d;
      if (accept) begin
        last_q <= in_last_i;
      end
    end
  end

  // window bytes
  always_ff @(posedge clk_i) begin
    win_q[0] <= win_d[0];
    win_q[1] <= win_d[1];
    win_q[2] <= win_d[2];
  end

  a_full_window_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd3) |-> !brk)
    else $error("full window stalled on a percent");

  a_last_clears_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (len_q == 16'd0))
    else $error("length counter not cleared at string end");

  a_no_esc_unescape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (tok_o.kind == pctesc_pkg::KIND_ESC)) |-> !unesc)
    else $error("escape token in unescape mode");

endmodule

// File: rtl/core/pctesc_fifo.sv
// short token queue between front and back
module pctesc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pctesc_pkg::tok_t  wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pctesc_pkg::tok_t  rdata_o
);

  localparam int unsigned Depth = pctesc_pkg::TOK_DEPTH;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);

  pctesc_pkg::tok_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("token pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("token popped from empty queue");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("queue level out of range");

endmodule

// File: rtl/core/pctesc_back.sv
// back end: expands tokens into output beats behind an output register
module pctesc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  input  pctesc_pkg::tok_t  tok_i,
  output logic              tok_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic              too_long_o
);

  pctesc_pkg::tok_t cur_q;
  logic             cur_valid_q;
  logic [1:0]       beat_q;
  logic             final_beat, take;

  assign final_beat = (cur_q.kind == pctesc_pkg::KIND_COPY) || (beat_q == pctesc_pkg::BEAT_LO);
  assign take       = !cur_valid_q || (pop_i && final_beat);
  assign tok_pop_o  = take && tok_valid_i;

  // beat selection
  always_comb begin
    case (beat_q)
      pctesc_pkg::BEAT_PCT: out_byte_o = (cur_q.kind == pctesc_pkg::KIND_ESC) ?
                                         pctesc_pkg::CHAR_PCT : cur_q.data;
      pctesc_pkg::BEAT_HI:  out_byte_o = pctesc_pkg::hex_char(cur_q.data[7:4]);
      pctesc_pkg::BEAT_LO:  out_byte_o = pctesc_pkg::hex_char(cur_q.data[3:0]);
      default:              out_byte_o = cur_q.data;
    endcase
  end

  assign empty_o    = !cur_valid_q;
  assign out_last_o = cur_q.last && final_beat;
  assign too_long_o = cur_q.tl;

  // current token and beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      beat_q      <= pctesc_pkg::BEAT_PCT;
    end else if (take) begin
      cur_valid_q <= tok_valid_i;
      beat_q      <= pctesc_pkg::BEAT_PCT;
    end else if (pop_i) begin
      beat_q <= beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= tok_i;
    end
  end

  a_beat_only_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && (beat_q != pctesc_pkg::BEAT_PCT)) |-> (cur_q.kind == pctesc_pkg::KIND_ESC))
    else $error("digit beat on a copied token");

  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q != 2'd3)
    else $error("beat counter out of range");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && cur_valid_q && final_beat && !tok_valid_i) |=> empty_o)
    else $error("output not empty after draining last token");

endmodule

// File: rtl/core/percent_escape_unescape.sv
// Percent-encoding codec, top level.
// Input channel: present in_byte_i/in_last_i with push_i; a beat is taken at a
// clock edge where push_i is high and full_o is low. in_last_i ends a string.
// Output channel: while empty_o is low the oldest output byte sits on
// out_byte_o/out_last_o/too_long_o; pop_i takes it at a clock edge.
// Config: cfg_we_i writes cfg_wdata_i into the mode register (0 escape data,
// 1 escape uri, 2 or 3 unescape); write it only while the block is idle.
// An input beat passes the lookahead window, token queue and output register
// before its first output byte shows. Throughput: one byte per cycle leaves
// the output register while pop_i is high; a copied byte goes out as one byte
// and an escaped byte as three. The front issues one token per cycle while the
// queue has room; a 4-entry token queue lets the two sides run apart. A '%'
// waits for its next two bytes unless its string ends or the first is not hex.
// Reset clears mode, lookahead, length counter, token queue and output.
// When pop_i stays low the output holds, the queue fills, and full_o rises.
module percent_escape_unescape #(
  parameter int unsigned MAX_LENGTH = pctesc_pkg::MAX_LENGTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pctesc_pkg::ModeW-1:0]  cfg_wdata_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_last_o,
  output logic                          too_long_o
);

  pctesc_pkg::tok_t front_tok, queue_tok;
  logic             front_push, queue_full, queue_valid, queue_pop;

  // classification
  pctesc_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .tok_push_o  (front_push),
    .tok_o       (front_tok),
    .tok_full_i  (queue_full)
  );

  // decoupling queue
  pctesc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_tok),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .rdata_o (queue_tok)
  );

  // output expansion
  pctesc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (queue_valid),
    .tok_i       (queue_tok),
    .tok_pop_o   (queue_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .too_long_o  (too_long_o)
  );

endmodule
